FILE: hw/rtl/sfd_pkg.sv
// Shared types and constants for the serial-bus frame decoder.
package sfd_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int OUT_COUNT_W = 32;

    localparam int NUM_CH     = 16;
    localparam int CH_W       = 11;
    localparam int CH_IDX_W   = 4;
    localparam int DATA_BYTES = 22;
    localparam int CHAN_BITS  = DATA_BYTES * 8;
    localparam int FLAG_W     = 4;

    localparam logic [4:0] POS_HEADER    = 5'd0;
    localparam logic [4:0] POS_LAST_DATA = 5'd22;
    localparam logic [4:0] POS_FLAGS     = 5'd23;
    localparam logic [4:0] POS_FOOTER    = 5'd24;

    localparam logic [7:0] FOOTER_A        = 8'h00;
    localparam logic [7:0] FOOTER_B        = 8'h04;
    localparam logic [7:0] START_BYTE_RST  = 8'h0F;

    localparam logic [CH_IDX_W-1:0] LAST_CH = CH_IDX_W'(NUM_CH - 1);

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // One decoded good frame waiting to be split into channel transactions.
    typedef struct packed {
        logic [CHAN_BITS-1:0]   chan_bits;
        logic [FLAG_W-1:0]      flags;
        logic [OUT_COUNT_W-1:0] good_count;
        logic [OUT_COUNT_W-1:0] bad_count;
    } t_frame;

endpackage

FILE: hw/rtl/sfd_front.sv
// Byte collector: frame sync, header/footer check and frame counters.
module sfd_front import sfd_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [7:0]   i_cfg_wr_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,
    input  logic         i_full,
    output logic         o_push,
    output t_frame       o_frame
);

    logic [7:0]             r_start_byte;
    logic [4:0]             r_pos;
    logic [7:0]             r_header;
    logic [CHAN_BITS-1:0]   r_chan;
    logic [FLAG_W-1:0]      r_flags;
    logic [COUNT_WIDTH-1:0] r_good;
    logic [COUNT_WIDTH-1:0] r_bad;
    logic [COUNT_WIDTH-1:0] n_good;
    logic [COUNT_WIDTH-1:0] n_bad;
    logic                   accept;
    logic                   frame_ok;

    // Only the footer byte can need queue space, so only it waits on a full queue.
    assign s_axis_tready = !((r_pos == POS_FOOTER) && i_full);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign frame_ok = (r_header == r_start_byte) &&
                      ((s_axis_tdata == FOOTER_A) || (s_axis_tdata == FOOTER_B));
    assign n_good   = r_good + 1'b1;
    assign n_bad    = r_bad + 1'b1;

    assign o_push             = accept && (r_pos == POS_FOOTER) && frame_ok;
    assign o_frame.chan_bits  = r_chan;
    assign o_frame.flags      = r_flags;
    assign o_frame.good_count = OUT_COUNT_W'(n_good);
    assign o_frame.bad_count  = OUT_COUNT_W'(r_bad);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= START_BYTE_RST;
            r_pos        <= POS_HEADER;
            r_good       <= '0;
            r_bad        <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_start_byte <= i_cfg_wr_data;
            end
            if (accept) begin
                if (r_pos == POS_HEADER) begin
                    if (s_axis_tdata == r_start_byte) begin
                        r_header <= s_axis_tdata;
                        r_pos    <= r_pos + 5'd1;
                    end
                end else if (r_pos <= POS_LAST_DATA) begin
                    // Bytes shift in from the top, so byte 1 ends up in the lowest bits.
                    r_chan <= {s_axis_tdata, r_chan[CHAN_BITS-1:8]};
                    r_pos  <= r_pos + 5'd1;
                end else if (r_pos == POS_FLAGS) begin
                    r_flags <= s_axis_tdata[FLAG_W-1:0];
                    r_pos   <= r_pos + 5'd1;
                end else begin
                    r_pos <= POS_HEADER;
                    if (frame_ok) begin
                        r_good <= n_good;
                    end else begin
                        r_bad <= n_bad;
                    end
                end
            end
        end
    end

endmodule

FILE: hw/rtl/sfd_fifo.sv
// Short frame queue between the byte collector and the channel emitter.
module sfd_fifo import sfd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_frame i_data,
    output logic   o_full,
    output logic   o_valid,
    output t_frame o_data,
    input  logic   i_pop
);

    t_frame            r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr;
    logic [Q_CW-1:0]   r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: hw/rtl/sfd_back.sv
// Channel emitter: splits one queued frame into sixteen channel transactions.
module sfd_back import sfd_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    input  t_frame                 i_q_frame,
    output logic                   o_pop,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [CH_IDX_W-1:0]    o_channel_index,
    output logic [CH_W-1:0]        o_channel_value,
    output logic [FLAG_W-1:0]      o_flags,
    output logic [OUT_COUNT_W-1:0] o_good_count,
    output logic [OUT_COUNT_W-1:0] o_bad_count,
    output logic                   m_axis_tlast
);

    logic                   r_busy;
    logic [CH_IDX_W-1:0]    r_idx;
    logic [CHAN_BITS-1:0]   r_bits;
    logic [FLAG_W-1:0]      r_flags;
    logic [OUT_COUNT_W-1:0] r_good;
    logic [OUT_COUNT_W-1:0] r_bad;
    logic                   accept;
    logic                   finish;
    logic                   load;

    assign accept = r_busy && m_axis_tready;
    assign finish = accept && (r_idx == LAST_CH);
    // A new frame loads in the same cycle the last channel leaves, so runs abut.
    assign load   = (!r_busy || finish) && i_q_valid;
    assign o_pop  = load;

    assign m_axis_tvalid   = r_busy;
    assign m_axis_tlast    = (r_idx == LAST_CH);
    assign o_channel_index = r_idx;
    assign o_channel_value = r_bits[CH_W-1:0];
    assign o_flags         = r_flags;
    assign o_good_count    = r_good;
    assign o_bad_count     = r_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (load) begin
            r_busy  <= 1'b1;
            r_idx   <= '0;
            r_bits  <= i_q_frame.chan_bits;
            r_flags <= i_q_frame.flags;
            r_good  <= i_q_frame.good_count;
            r_bad   <= i_q_frame.bad_count;
        end else if (finish) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (accept) begin
            r_idx  <= r_idx + 1'b1;
            r_bits <= r_bits >> CH_W;
        end
    end

`ifndef NO_ASSERTIONS
    a_idx_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (r_idx != LAST_CH)) |=>
            (r_busy && (r_idx == $past(r_idx) + 1'b1)))
        else $error("channel index did not advance by one");

    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (finish && !i_q_valid) |=> !r_busy)
        else $error("emitter stayed busy after the last channel with no frame queued");

    a_count_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (r_idx != LAST_CH)) |=> $stable(r_good) && $stable(r_bad))
        else $error("frame counts changed inside a channel run");

    a_pop_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (i_q_valid && (!r_busy || finish)))
        else $error("queue popped while a frame was still being emitted");
`endif

endmodule

FILE: hw/rtl/sbus_frame_decoder.sv
// After its footer byte, a good frame goes through the frame queue into the emitter registers.
// Throughput: one byte per cycle in; one channel per cycle out while ready, 16 per good frame.
// The input stalls only on a footer byte while two decoded frames wait in the queue.
// Reset is synchronous, active low: frame sync, both counters and the queue clear,
// and the start byte returns to 0x0F.
module sbus_frame_decoder import sfd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] channel_index, [14:4] channel_value, [15] aux_channel_17,
    // [16] aux_channel_18, [17] frame_drop, [18] failsafe,
    // [50:19] good_frame_count, [82:51] bad_frame_count, [87:83] zero
    output logic [87:0] m_axis_tdata,
    output logic        m_axis_tlast    // last_channel
);

    logic                   push;
    t_frame                 push_frame;
    logic                   q_full;
    logic                   q_valid;
    t_frame                 q_frame;
    logic                   pop;
    logic [CH_IDX_W-1:0]    channel_index;
    logic [CH_W-1:0]        channel_value;
    logic [FLAG_W-1:0]      flags;
    logic [OUT_COUNT_W-1:0] good_count;
    logic [OUT_COUNT_W-1:0] bad_count;

    sfd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_full        (q_full),
        .o_push        (push),
        .o_frame       (push_frame)
    );

    sfd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_frame),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_frame),
        .i_pop   (pop)
    );

    sfd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_frame       (q_frame),
        .o_pop           (pop),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .o_channel_index (channel_index),
        .o_channel_value (channel_value),
        .o_flags         (flags),
        .o_good_count    (good_count),
        .o_bad_count     (bad_count),
        .m_axis_tlast    (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, bad_count, good_count, flags, channel_value, channel_index};

endmodule

FILE: tb/sbus_frame_decoder_tb.sv
// Self-checking serial-bus frame decoder bench: directed frames, random traffic, output hold-off.
`timescale 1ns / 100ps

module sbus_frame_decoder_tb;
    import sfd_pkg::*;

    localparam int FRAME_BYTES     = 25;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int QUIET_LIMIT     = 4000;
    localparam int RANDOM_BYTES    = 30;
    localparam int PRESSURE_FRAMES = 4;

    typedef struct {
        logic [CH_IDX_W-1:0]    index;
        logic [CH_W-1:0]        value;
        logic                   aux17;
        logic                   aux18;
        logic                   lost;
        logic                   failsafe;
        logic                   last;
        logic [OUT_COUNT_W-1:0] good;
        logic [OUT_COUNT_W-1:0] bad;
    } t_channel;

    // One directed frame. A negative start or mid-frame start means no register write;
    // a negative channel value means the decoded channels are predicted from the frame bytes.
    typedef struct {
        int         new_start;
        int         lead_junk;
        logic [7:0] fill;
        bit         rnd_body;
        logic [7:0] flags;
        logic [7:0] footer;
        int         mid_start;
        int         chan_value;
    } t_frame_case;

    t_frame_case directed_frames [4] = '{
        '{-1,    0, 8'h00, 1'b0, 8'h00, FOOTER_A, -1,    0},
        '{-1,    3, 8'hFF, 1'b0, 8'hFF, FOOTER_B, -1,    2047},
        '{8'h00, 1, 8'h55, 1'b0, 8'h05, 8'h08,    -1,    -1},
        '{-1,    0, 8'h00, 1'b1, 8'h0A, FOOTER_A, 8'h3C, -1}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [7:0]  i_cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [3:0] channel_index, [14:4] channel_value, [15] aux_channel_17,
    // [16] aux_channel_18, [17] frame_drop, [18] failsafe,
    // [50:19] good_frame_count, [82:51] bad_frame_count, [87:83] zero
    logic [87:0] m_axis_tdata;
    logic        m_axis_tlast;   // last_channel

    // Predictor state.
    logic [7:0]             start_byte_m;
    int                     frame_pos;
    logic [7:0]             frame_buf [FRAME_BYTES];
    logic [COUNT_WIDTH-1:0] good_frames_m;
    logic [COUNT_WIDTH-1:0] bad_frames_m;

    t_channel   pending_channels [$];
    t_channel   oldest;
    logic [7:0] frame_body [1:DATA_BYTES];
    int         err_count;
    int         bytes_sent;
    int         hold_requests;
    bit         calm;

    sbus_frame_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Advances the frame predictor by one accepted byte and queues the channels it releases.
    task automatic decode_byte(input logic [7:0] rx, input int chan_value);
        logic [CHAN_BITS-1:0] chan_bits;
        t_channel             ch;
        if (frame_pos == 0 && rx != start_byte_m) return;
        frame_buf[frame_pos] = rx;
        frame_pos++;
        if (frame_pos < FRAME_BYTES) return;
        frame_pos = 0;
        if (frame_buf[POS_HEADER] != start_byte_m ||
            (frame_buf[POS_FOOTER] != FOOTER_A && frame_buf[POS_FOOTER] != FOOTER_B)) begin
            bad_frames_m++;
            return;
        end
        good_frames_m++;
        for (int i = 1; i <= DATA_BYTES; i++) begin
            chan_bits[8*(i-1) +: 8] = frame_buf[i];
        end
        for (int k = 0; k < NUM_CH; k++) begin
            ch.index    = CH_IDX_W'(k);
            ch.value    = (chan_value >= 0) ? CH_W'(chan_value) : chan_bits[CH_W*k +: CH_W];
            ch.aux17    = frame_buf[POS_FLAGS][0];
            ch.aux18    = frame_buf[POS_FLAGS][1];
            ch.lost     = frame_buf[POS_FLAGS][2];
            ch.failsafe = frame_buf[POS_FLAGS][3];
            ch.last     = (ch.index == LAST_CH);
            ch.good     = OUT_COUNT_W'(good_frames_m);
            ch.bad      = OUT_COUNT_W'(bad_frames_m);
            pending_channels.push_back(ch);
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_byte(input logic [7:0] rx, input int chan_value);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = rx;
        do @(posedge i_clk); while (!s_axis_tready);
        decode_byte(rx, chan_value);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // The start byte is only rewritten once the output side has drained.
    task automatic set_start(input logic [7:0] value);
        s_axis_tvalid = 1'b0;
        while (pending_channels.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = value;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        start_byte_m  = value;
    endtask

    task automatic fill_body(input logic [7:0] fill, input bit rnd_body);
        for (int i = 1; i <= DATA_BYTES; i++) begin
            frame_body[i] = rnd_body ? 8'($urandom_range(0, 255)) : fill;
        end
    endtask

    task automatic send_frame(input logic [7:0] header, input logic [7:0] flags,
                              input logic [7:0] footer, input int chan_value,
                              input int mid_start);
        send_byte(header, chan_value);
        for (int i = 1; i <= DATA_BYTES; i++) begin
            if (i == 10 && mid_start >= 0) set_start(8'(mid_start));
            send_byte(frame_body[i], chan_value);
        end
        send_byte(flags, chan_value);
        send_byte(footer, chan_value);
    endtask

    task automatic send_good_frame();
        fill_body(8'h00, 1'b1);
        send_frame(start_byte_m, 8'($urandom_range(0, 255)),
                   $urandom_range(0, 1) ? FOOTER_B : FOOTER_A, -1, -1);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_channels.size() == 0) begin
                $display("%0t ns: channel transaction %h with none expected",
                         $time, m_axis_tdata);
                err_count++;
            end else begin
                oldest = pending_channels.pop_front();
                check_field("channel_index", 32'(oldest.index), 32'(m_axis_tdata[3:0]));
                check_field("channel_value", 32'(oldest.value), 32'(m_axis_tdata[14:4]));
                check_field("aux_channel_17", 32'(oldest.aux17), 32'(m_axis_tdata[15]));
                check_field("aux_channel_18", 32'(oldest.aux18), 32'(m_axis_tdata[16]));
                check_field("frame_drop", 32'(oldest.lost), 32'(m_axis_tdata[17]));
                check_field("failsafe", 32'(oldest.failsafe), 32'(m_axis_tdata[18]));
                check_field("last_channel", 32'(oldest.last), 32'(m_axis_tlast));
                check_field("good_frame_count", oldest.good, m_axis_tdata[50:19]);
                check_field("bad_frame_count", oldest.bad, m_axis_tdata[82:51]);
            end
        end
    end

    // Output side: random stall bursts, plus one long hold-off on request.
    initial begin
        int holds_served;
        holds_served  = 0;
        m_axis_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            if (hold_requests != holds_served) begin
                holds_served  = hold_requests;
                m_axis_tready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
            end else begin
                m_axis_tready = 1'b1;
                @(negedge i_clk);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("sbus_frame_decoder: mismatch");
        $finish;
    end

    initial begin
        int         first_byte;
        int         kind;
        logic [7:0] junk;
        logic [7:0] footer;

        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 8'h00;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        start_byte_m  = START_BYTE_RST;
        frame_pos     = 0;
        good_frames_m = '0;
        bad_frames_m  = '0;
        err_count     = 0;
        bytes_sent    = 0;
        hold_requests = 0;
        calm          = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_frames[r]) begin
            if (directed_frames[r].new_start >= 0) set_start(8'(directed_frames[r].new_start));
            repeat (directed_frames[r].lead_junk) begin
                junk = 8'($urandom_range(0, 255));
                if (junk == start_byte_m) junk = junk ^ 8'h01;
                send_byte(junk, -1);
            end
            fill_body(directed_frames[r].fill, directed_frames[r].rnd_body);
            send_frame(start_byte_m, directed_frames[r].flags, directed_frames[r].footer,
                       directed_frames[r].chan_value, directed_frames[r].mid_start);
        end

        // Mostly well-formed frames; the rest are bad footers, line noise and cut-off
        // frames that force the decoder to resynchronize.
        first_byte = bytes_sent;
        while (bytes_sent - first_byte < RANDOM_BYTES) begin
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 11) == 0) set_start(8'($urandom_range(0, 255)));
            kind = $urandom_range(0, 99);
            if (kind < 65) begin
                send_good_frame();
            end else if (kind < 80) begin
                footer = 8'($urandom_range(0, 255));
                if (footer == FOOTER_A || footer == FOOTER_B) footer = footer | 8'h80;
                fill_body(8'h00, 1'b1);
                send_frame(start_byte_m, 8'($urandom_range(0, 255)), footer, -1, -1);
            end else if (kind < 90) begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)), -1);
            end else begin
                send_byte(start_byte_m, -1);
                repeat ($urandom_range(1, 23)) send_byte(8'($urandom_range(0, 255)), -1);
            end
        end

        // Frames keep coming while the output is held off, so the frame queue fills.
        calm = 1'b1;
        hold_requests++;
        repeat (PRESSURE_FRAMES) send_good_frame();

        s_axis_tvalid = 1'b0;
        while (pending_channels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0 && pending_channels.size() == 0)
            $display("sbus_frame_decoder: match");
        else
            $display("sbus_frame_decoder: mismatch");
        $finish;
    end

endmodule
